FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the correlation block's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/swc_pkg.sv
// Shared types and constants for the sliding-window correlation block.
`timescale 1ns / 1ps
package swc_pkg;

  // Configuration port
  localparam int CFG_DW  = 32;
  localparam int PADDR_W = 3;
  localparam int WSIZE_W = 13;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 13'd256;

  // Register select (paddr bit 2)
  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_MODE        = 1'b1;

  // Result format, Q1.15
  localparam int CORR_W = 16;
  localparam int QUOT_W = 17;
  localparam logic [QUOT_W-1:0] Q_ONE     = 17'h08000;
  localparam logic [QUOT_W-1:0] Q_MAX_POS = 17'h07FFF;
  localparam logic [QUOT_W-1:0] Q_OVER    = 17'h10000;

  // Window store control
  typedef struct packed {
    logic clear;
    logic load;
  } win_ctl_t;

endpackage

FILE: hw/rtl/swc_window.sv
// Sample delay line in a synchronous memory plus the five running sums.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module swc_window #(
  parameter int MAX_WINDOW  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  swc_pkg::win_ctl_t                          ctl,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]            n,
  input  logic signed [SAMPLE_BITS-1:0]              x_in,
  input  logic signed [SAMPLE_BITS-1:0]              y_in,
  output logic                                       done,
  output logic signed [SAMPLE_BITS+$clog2(MAX_WINDOW):0]   sum_x,
  output logic signed [SAMPLE_BITS+$clog2(MAX_WINDOW):0]   sum_y,
  output logic signed [2*SAMPLE_BITS+$clog2(MAX_WINDOW):0] sum_xy,
  output logic signed [2*SAMPLE_BITS+$clog2(MAX_WINDOW):0] sum_xx,
  output logic signed [2*SAMPLE_BITS+$clog2(MAX_WINDOW):0] sum_yy
);
  import swc_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int NW    = $clog2(MAX_WINDOW + 1);
  localparam int XW    = AW + 1;
  localparam int PW    = 2 * SB;
  localparam int SUMW  = SB + AW + 1;
  localparam int PSUMW = 2 * SB + AW + 1;

  typedef enum logic [1:0] {P_IDLE, P_OLD, P_SUM} phase_t;

  phase_t               phase;
  logic [PW-1:0]        mem [MAX_WINDOW];
  logic [PW-1:0]        rd_data;
  logic [AW-1:0]        wr_idx;
  logic [NW-1:0]        fill;
  logic                 sub;
  logic signed [SB-1:0] nx, ny, ox, oy;
  logic signed [PW-1:0] pn_xy, pn_xx, pn_yy, po_xy, po_xx, po_yy;
  logic [XW-1:0]        wi, nn, old_idx;

  // Entry leaving the window: n places behind the write pointer
  always_comb begin
    wi = XW'(wr_idx);
    nn = XW'(n);
    if (wi >= nn) begin
      old_idx = wi - nn;
    end else begin
      old_idx = wi + XW'(MAX_WINDOW) - nn;
    end
  end

  // Memory: read on load, write the new pair in the cycle after
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rd_data <= mem[old_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (phase == P_OLD) begin
      mem[wr_idx] <= {ny, nx};
    end
  end

  // Payload products, new pair then leaving pair
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      nx    <= x_in;
      ny    <= y_in;
      pn_xy <= PW'(x_in) * PW'(y_in);
      pn_xx <= PW'(x_in) * PW'(x_in);
      pn_yy <= PW'(y_in) * PW'(y_in);
    end
    if (phase == P_OLD) begin
      ox    <= rd_data[SB-1:0];
      oy    <= rd_data[PW-1:SB];
      po_xy <= PW'($signed(rd_data[SB-1:0])) * PW'($signed(rd_data[PW-1:SB]));
      po_xx <= PW'($signed(rd_data[SB-1:0])) * PW'($signed(rd_data[SB-1:0]));
      po_yy <= PW'($signed(rd_data[PW-1:SB])) * PW'($signed(rd_data[PW-1:SB]));
    end
  end

  // Sequencing, pointers and running sums
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      phase  <= P_IDLE;
      done   <= 1'b0;
      wr_idx <= '0;
      fill   <= '0;
      sub    <= 1'b0;
      sum_x  <= '0;
      sum_y  <= '0;
      sum_xy <= '0;
      sum_xx <= '0;
      sum_yy <= '0;
    end else begin
      done <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (ctl.load) begin
            sub   <= (fill >= n);
            phase <= P_OLD;
          end
        end
        P_OLD: begin
          wr_idx <= (wr_idx == AW'(MAX_WINDOW - 1)) ? '0 : wr_idx + 1'b1;
          phase  <= P_SUM;
        end
        P_SUM: begin
          if (sub) begin
            sum_x  <= sum_x + SUMW'(nx) - SUMW'(ox);
            sum_y  <= sum_y + SUMW'(ny) - SUMW'(oy);
            sum_xy <= sum_xy + PSUMW'(pn_xy) - PSUMW'(po_xy);
            sum_xx <= sum_xx + PSUMW'(pn_xx) - PSUMW'(po_xx);
            sum_yy <= sum_yy + PSUMW'(pn_yy) - PSUMW'(po_yy);
          end else begin
            sum_x  <= sum_x + SUMW'(nx);
            sum_y  <= sum_y + SUMW'(ny);
            sum_xy <= sum_xy + PSUMW'(pn_xy);
            sum_xx <= sum_xx + PSUMW'(pn_xx);
            sum_yy <= sum_yy + PSUMW'(pn_yy);
            fill   <= fill + 1'b1;
          end
          done  <= 1'b1;
          phase <= P_IDLE;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_fill_in_window, clk, rst, 1'b1, fill <= n, "fill count beyond window")

endmodule

FILE: hw/rtl/swc_mul.sv
// Shared shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module swc_mul #(
  parameter int AW = 45,
  parameter int BW = 32,
  parameter int PW = 61
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic                 busy,
  output logic                 done,
  output logic signed [PW-1:0] p
);
  import swc_pkg::*;

  localparam int CW = $clog2(BW + 1);

  logic [PW-1:0] a_sh, acc, sum;
  logic [BW-1:0] b_mag;
  logic          neg;
  logic [CW-1:0] cnt;

  assign sum = acc + (b_mag[0] ? a_sh : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          a_sh  <= PW'(a);
          b_mag <= b[BW-1] ? BW'(-b) : BW'(b);
          neg   <= b[BW-1];
          acc   <= '0;
          cnt   <= CW'(BW);
          busy  <= 1'b1;
        end
      end else begin
        acc   <= sum;
        a_sh  <= a_sh << 1;
        b_mag <= b_mag >> 1;
        cnt   <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          p    <= neg ? $signed(-sum) : $signed(sum);
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "multiplier did not start")

endmodule

FILE: hw/rtl/swc_root.sv
// Integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module swc_root #(
  parameter int VW = 61,
  parameter int RW = 31
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [VW-1:0] v,
  output logic          done,
  output logic [RW-1:0] root
);
  import swc_pkg::*;

  localparam int VP = 2 * RW;
  localparam int CW = $clog2(RW + 1);

  logic          busy;
  logic [VP-1:0] vs;
  logic [RW+1:0] rem, rem_sh, trial;
  logic [CW-1:0] cnt;

  assign rem_sh = {rem[RW-1:0], vs[VP-1:VP-2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          vs   <= VP'(v);
          rem  <= '0;
          root <= '0;
          cnt  <= CW'(RW);
          busy <= 1'b1;
        end
      end else begin
        vs  <= vs << 2;
        cnt <= cnt - 1'b1;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[RW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[RW-2:0], 1'b0};
        end
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/swc_div.sv
// Restoring divider for |num| * 2^15 / den, saturating at 2^16.
`timescale 1ns / 1ps
module swc_div #(
  parameter int WW = 61
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [WW-1:0]               num,
  input  logic [WW-1:0]               den,
  output logic                        done,
  output logic [swc_pkg::QUOT_W-1:0]  q
);
  import swc_pkg::*;

  localparam int RMW = WW + QUOT_W;

  logic           busy, first;
  logic [RMW-1:0] rem, dsh;
  logic [4:0]     cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          rem   <= RMW'(num) << 15;
          dsh   <= RMW'(den) << 16;
          q     <= '0;
          first <= 1'b1;
          busy  <= 1'b1;
        end
      end else if (first) begin
        // quotient of 2^16 or more saturates at once
        first <= 1'b0;
        if (rem >= dsh) begin
          q    <= Q_OVER;
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          dsh <= dsh >> 1;
          cnt <= 5'd16;
        end
      end else begin
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
        if (rem >= dsh) begin
          rem <= rem - dsh;
          q   <= {q[QUOT_W-2:0], 1'b1};
        end else begin
          q   <= {q[QUOT_W-2:0], 1'b0};
        end
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/sliding_window_correlation_top.sv
// Sliding-window correlation of two sample streams.
//
// Input stream s_*: one transfer carries an x and y sample pair. Output
// stream m_*: one Q1.15 correlation per input pair, saturated to [-1, 1).
// Registers on the APB port: window_size at 0x0, mode at 0x4 (0 Pearson,
// 1 uncentred). Writing window_size empties the window and its sums.
//
// Each pair's processing time is set by the shared shift-add multiplier
// (seven products, one multiplier bit a cycle), the bit-serial root unit
// (two roots) and the 17-step divider. Items are processed one at a time;
// s_tready is high only between items. The sample memory is read in the
// cycle before the new pair is written, so full-length windows need no
// bypass.
//
// Reset empties the window, sets window_size 256 and mode 0. A finished
// result sits in the output register while m_tready is low; the next pair
// may be taken meanwhile and its result waits until the register is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sliding_window_correlation_top #(
  parameter int MAX_WINDOW  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // s_tdata: x_sample, y_sample (lowest first)
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
  // m_tdata: correlation
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [swc_pkg::CORR_W-1:0]          m_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swc_pkg::PADDR_W-1:0]         paddr,
  input  logic [swc_pkg::CFG_DW-1:0]          pwdata,
  output logic [swc_pkg::CFG_DW-1:0]          prdata,
  output logic                                pready
);
  import swc_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int NW    = $clog2(MAX_WINDOW + 1);
  localparam int SUMW  = SB + AW + 1;
  localparam int PSUMW = 2 * SB + AW + 1;
  localparam int WW    = 2 * SUMW + 3;
  localparam int RW    = (WW + 1) / 2;
  localparam int MBW   = RW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_WIN, S_MUL, S_ROOTX, S_ROOTY, S_DEN, S_DIV, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    PR_NXY, PR_CXY, PR_NXX, PR_CXX, PR_NYY, PR_CYY, PR_DEN
  } prod_t;

  state_t                   state;
  prod_t                    step;
  logic [WSIZE_W-1:0]       window_size;
  logic                     mode;
  logic [NW-1:0]            n, mult;
  logic                     cfg_wr, accept;
  win_ctl_t                 win_ctl;
  logic                     win_done;
  logic signed [SUMW-1:0]   sum_x, sum_y, cx, cy;
  logic signed [PSUMW-1:0]  sum_xy, sum_xx, sum_yy;
  logic signed [PSUMW-1:0]  mul_a;
  logic signed [MBW-1:0]    mul_b;
  logic                     mul_start, mul_busy, mul_done;
  logic signed [WW-1:0]     mul_p;
  logic signed [WW-1:0]     num, dx, dy;
  logic [WW-1:0]            den, num_mag, root_in;
  logic                     root_start, root_done;
  logic [RW-1:0]            root, rx, ry;
  logic                     div_start, div_done;
  logic [QUOT_W-1:0]        quot, qm;
  logic [QUOT_W-1:0]        val;
  logic [CORR_W-1:0]        corr;
  logic [CORR_W-1:0]        res;

  // Configuration registers
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WSIZE_RESET;
      mode        <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_WINDOW_SIZE: window_size <= pwdata[WSIZE_W-1:0];
        REG_MODE:        mode        <= pwdata[0];
        default:         mode        <= mode;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WINDOW_SIZE: prdata = CFG_DW'(window_size);
      REG_MODE:        prdata = CFG_DW'(mode);
      default:         prdata = '0;
    endcase
  end

  // Effective window length
  always_comb begin
    if (window_size == '0) begin
      n = NW'(1);
    end else if (32'(window_size) > MAX_WINDOW) begin
      n = NW'(MAX_WINDOW);
    end else begin
      n = NW'(window_size);
    end
  end

  assign accept          = s_tvalid && s_tready;
  assign s_tready        = (state == S_IDLE);
  assign win_ctl.load    = accept;
  assign win_ctl.clear   = cfg_wr && (paddr[2] == REG_WINDOW_SIZE);

  swc_window #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_window (
    .clk   (clk),
    .rst   (rst),
    .ctl   (win_ctl),
    .n     (n),
    .x_in  ($signed(s_tdata[SB-1:0])),
    .y_in  ($signed(s_tdata[2*SB-1:SB])),
    .done  (win_done),
    .sum_x (sum_x),
    .sum_y (sum_y),
    .sum_xy(sum_xy),
    .sum_xx(sum_xx),
    .sum_yy(sum_yy)
  );

  // Mode selects the scale and the centring terms
  assign mult = mode ? NW'(1) : n;
  assign cx   = mode ? '0 : sum_x;
  assign cy   = mode ? '0 : sum_y;

  // Multiplier operands for each product
  always_comb begin
    case (step)
      PR_NXY: begin mul_a = sum_xy;                 mul_b = $signed(MBW'(mult)); end
      PR_CXY: begin mul_a = PSUMW'(cx);             mul_b = MBW'(cy);            end
      PR_NXX: begin mul_a = sum_xx;                 mul_b = $signed(MBW'(mult)); end
      PR_CXX: begin mul_a = PSUMW'(cx);             mul_b = MBW'(cx);            end
      PR_NYY: begin mul_a = sum_yy;                 mul_b = $signed(MBW'(mult)); end
      PR_CYY: begin mul_a = PSUMW'(cy);             mul_b = MBW'(cy);            end
      PR_DEN: begin mul_a = $signed(PSUMW'(rx));    mul_b = $signed(MBW'(ry));   end
      default: begin mul_a = '0;                    mul_b = '0;                  end
    endcase
  end

  swc_mul #(.AW(PSUMW), .BW(MBW), .PW(WW)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .busy (mul_busy),
    .done (mul_done),
    .p    (mul_p)
  );

  swc_root #(.VW(WW), .RW(RW)) u_root (
    .clk  (clk),
    .rst  (rst),
    .start(root_start),
    .v    (root_in),
    .done (root_done),
    .root (root)
  );

  assign num_mag = num[WW-1] ? WW'(-num) : WW'(num);

  swc_div #(.WW(WW)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num_mag),
    .den  (den),
    .done (div_done),
    .q    (quot)
  );

  // Signed, saturated Q1.15 result
  always_comb begin
    if (num[WW-1]) begin
      qm  = (quot > Q_ONE) ? Q_ONE : quot;
      val = QUOT_W'(0) - qm;
    end else begin
      qm  = (quot > Q_MAX_POS) ? Q_MAX_POS : quot;
      val = qm;
    end
    corr = val[CORR_W-1:0];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= PR_NXY;
      mul_start  <= 1'b0;
      root_start <= 1'b0;
      div_start  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      mul_start  <= 1'b0;
      root_start <= 1'b0;
      div_start  <= 1'b0;
      // Output register: take the held result once it is free
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata  <= res;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_WIN;
          end
        end
        S_WIN: begin
          if (win_done) begin
            step      <= PR_NXY;
            mul_start <= 1'b1;
            state     <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            case (step)
              PR_NXY:  num <= mul_p;
              PR_CXY:  num <= num - mul_p;
              PR_NXX:  dx  <= mul_p;
              PR_CXX:  dx  <= dx - mul_p;
              PR_NYY:  dy  <= mul_p;
              default: dy  <= dy - mul_p;
            endcase
            if (step == PR_CYY) begin
              // negative energy counts as zero
              root_in    <= dx[WW-1] ? '0 : WW'(dx);
              root_start <= 1'b1;
              state      <= S_ROOTX;
            end else begin
              step      <= prod_t'(step + 3'd1);
              mul_start <= 1'b1;
            end
          end
        end
        S_ROOTX: begin
          if (root_done) begin
            rx         <= root;
            root_in    <= dy[WW-1] ? '0 : WW'(dy);
            root_start <= 1'b1;
            state      <= S_ROOTY;
          end
        end
        S_ROOTY: begin
          if (root_done) begin
            ry        <= root;
            step      <= PR_DEN;
            mul_start <= 1'b1;
            state     <= S_DEN;
          end
        end
        S_DEN: begin
          if (mul_done) begin
            den <= WW'(mul_p);
            if (mul_p == '0) begin
              res   <= '0;
              state <= S_OUT;
            end else begin
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            res   <= corr;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // result held in res until the output register frees
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_accept_blocks, clk, rst, accept, !s_tready, "second transfer taken mid-item")
  `ASSERT_IMPLIES(a_mul_idle_start, clk, rst, mul_start, !mul_busy, "multiplier started while busy")

endmodule
